### hw/rtl/wple_pkg.sv
// Package: opcodes, payload types, back-end states and shared fixed-point helpers.
package wple_pkg;

  typedef enum logic [1:0] {
    OP_LINE  = 2'd0,
    OP_ARROW = 2'd1,
    OP_BOX   = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_EMIT
  } bstate_t;

  typedef struct packed {
    logic [1:0]   opcode;
    logic signed [31:0] ax, ay, az;
    logic signed [31:0] bx, by, bz;
    logic signed [31:0] cx, cy, cz;
    logic [31:0]  rgba;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] start_x, start_y, start_z;
    logic signed [31:0] end_x, end_y, end_z;
    logic [31:0]  line_color;
    logic         last_line;
  } seg_t;

  localparam int QUEUE_DEPTH = 2;

  // Saturate a 34-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) r = 32'sh7fffffff;
    else if (v < -34'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Floor a 64-bit Q32.32 product to Q16.16, kept at 48 bits unsaturated.
  function automatic logic signed [47:0] flq(input logic signed [63:0] p);
    return p[63:16];
  endfunction

  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = 32'sh7fffffff;
    else if (v < -48'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Difference of two floored products, widened by one bit and saturated.
  function automatic logic signed [31:0] sub_sat48(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
    logic signed [48:0] d;
    logic signed [31:0] r;
    d = 49'(a) - 49'(b);
    if (d > 49'sd2147483647) r = 32'sh7fffffff;
    else if (d < -49'sd2147483648) r = 32'sh80000000;
    else r = d[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    return sat34(34'(a) + 34'(b));
  endfunction

endpackage

### hw/rtl/wple_if.sv
// Valid/ready channel interfaces for commands and segments.
interface wple_cmd_if;
  logic              valid;
  logic              ready;
  wple_pkg::cmd_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wple_seg_if;
  logic              valid;
  logic              ready;
  wple_pkg::seg_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/wple_front.sv
// Front part: accepts commands, drops unused opcodes, queues the rest.
module wple_front #(
  parameter int Depth = wple_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  wple_cmd_if.sink           cmd,
  output logic               q_valid,
  input  logic               q_pop,
  output wple_pkg::cmd_t     q_data
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  wple_pkg::cmd_t  mem [Depth];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;
  logic            push;

  assign cmd.ready = (count != (AW+1)'(Depth));
  assign push = cmd.valid && cmd.ready &&
                (wple_pkg::opcode_t'(cmd.data.opcode) != wple_pkg::OP_NONE);
  assign q_valid = (count != '0);
  assign q_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end
endmodule

### hw/rtl/wple_back.sv
// Back part: computes the vertices of one command and emits its segments.
module wple_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_pop,
  input  wple_pkg::cmd_t   q_data,
  wple_seg_if.source       seg
);
  wple_pkg::bstate_t state, state_next;
  wple_pkg::cmd_t cmd;
  logic [3:0] idx;
  logic [3:0] nseg;

  // Arrow intermediates.
  logic signed [31:0] tip [3];
  logic signed [31:0] back [3];
  logic signed [32:0] orth [3];
  logic signed [31:0] w2 [3];
  logic signed [31:0] w3 [3];
  logic signed [31:0] half;
  logic signed [31:0] diff;
  logic signed [47:0] pa [3];
  logic signed [47:0] pb [3];

  // One bank of six multipliers, shared by every arrow phase. The second
  // operand is one bit wider so that a negated ortho component stays exact.
  logic signed [31:0] ma [6];
  logic signed [32:0] mb [6];
  logic signed [63:0] mp [6];

  logic out_free;
  assign out_free = !seg.valid || seg.ready;
  assign q_pop = (state == wple_pkg::S_IDLE) && q_valid;

  always_comb begin
    for (int n = 0; n < 6; n++) mp[n] = 64'(ma[n]) * 64'(mb[n]);
  end

  // Operand selection per phase.
  always_comb begin
    logic signed [31:0] b [3];
    b[0] = cmd.bx; b[1] = cmd.by; b[2] = cmd.bz;
    for (int n = 0; n < 6; n++) begin
      ma[n] = '0;
      mb[n] = '0;
    end
    case (state)
      wple_pkg::S_MUL1: begin
        for (int n = 0; n < 3; n++) begin
          ma[n] = b[n]; mb[n] = 33'(cmd.cx);
          ma[n+3] = b[n]; mb[n+3] = 33'(diff);
        end
      end
      wple_pkg::S_MUL2: begin
        ma[0] = b[1]; mb[0] = orth[2]; ma[3] = b[2]; mb[3] = orth[1];
        ma[1] = b[2]; mb[1] = orth[0]; ma[4] = b[0]; mb[4] = orth[2];
        ma[2] = b[0]; mb[2] = orth[1]; ma[5] = b[1]; mb[5] = orth[0];
      end
      wple_pkg::S_MUL3: begin
        ma[0] = b[1]; mb[0] = 33'(w2[2]); ma[3] = b[2]; mb[3] = 33'(w2[1]);
        ma[1] = b[2]; mb[1] = 33'(w2[0]); ma[4] = b[0]; mb[4] = 33'(w2[2]);
        ma[2] = b[0]; mb[2] = 33'(w2[1]); ma[5] = b[1]; mb[5] = 33'(w2[0]);
      end
      wple_pkg::S_MUL4: begin
        for (int n = 0; n < 3; n++) begin
          ma[n] = w2[n]; mb[n] = 33'(half);
          ma[n+3] = w3[n]; mb[n+3] = 33'(half);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      wple_pkg::S_IDLE: begin
        if (q_valid) begin
          state_next = (wple_pkg::opcode_t'(q_data.opcode) == wple_pkg::OP_ARROW)
                       ? wple_pkg::S_MUL1 : wple_pkg::S_EMIT;
        end
      end
      wple_pkg::S_MUL1: state_next = wple_pkg::S_MUL2;
      wple_pkg::S_MUL2: state_next = wple_pkg::S_MUL3;
      wple_pkg::S_MUL3: state_next = wple_pkg::S_MUL4;
      wple_pkg::S_MUL4: state_next = wple_pkg::S_EMIT;
      wple_pkg::S_EMIT: begin
        if (out_free && idx == nseg) state_next = wple_pkg::S_IDLE;
      end
      default: state_next = wple_pkg::S_IDLE;
    endcase
  end

  // Ortho vector and derived constants from the dequeued command.
  function automatic void mk_orth(input wple_pkg::cmd_t c,
                                  output logic signed [32:0] o [3]);
    logic signed [31:0] b [3];
    logic [32:0] m [3];
    logic [1:0] i, j;
    b[0] = c.bx; b[1] = c.by; b[2] = c.bz;
    for (int n = 0; n < 3; n++) m[n] = b[n][31] ? 33'(-34'(b[n])) : 33'(b[n]);
    i = 2'd0;
    if (m[1] > m[0]) i = 2'd1;
    if (m[2] > m[i]) i = 2'd2;
    j = (i == 2'd2) ? 2'd0 : i + 2'd1;
    for (int n = 0; n < 3; n++) o[n] = 33'(b[n]);
    o[i] = 33'(-34'(b[j]));
    o[j] = 33'(b[i]);
  endfunction

  always_ff @(posedge clk) begin
    logic signed [32:0] o [3];
    case (state)
      wple_pkg::S_IDLE: begin
        if (q_valid) begin
          cmd <= q_data;
          diff <= wple_pkg::sat34(34'(q_data.cx) - 34'(q_data.cy));
          half <= q_data.cy >>> 1;
          mk_orth(q_data, o);
          for (int n = 0; n < 3; n++) orth[n] <= o[n];
        end
      end
      wple_pkg::S_MUL1: begin
        tip[0] <= wple_pkg::add_sat(cmd.ax, wple_pkg::sat48(wple_pkg::flq(mp[0])));
        tip[1] <= wple_pkg::add_sat(cmd.ay, wple_pkg::sat48(wple_pkg::flq(mp[1])));
        tip[2] <= wple_pkg::add_sat(cmd.az, wple_pkg::sat48(wple_pkg::flq(mp[2])));
        back[0] <= wple_pkg::add_sat(cmd.ax, wple_pkg::sat48(wple_pkg::flq(mp[3])));
        back[1] <= wple_pkg::add_sat(cmd.ay, wple_pkg::sat48(wple_pkg::flq(mp[4])));
        back[2] <= wple_pkg::add_sat(cmd.az, wple_pkg::sat48(wple_pkg::flq(mp[5])));
      end
      wple_pkg::S_MUL2: begin
        for (int n = 0; n < 3; n++)
          w2[n] <= wple_pkg::sub_sat48(wple_pkg::flq(mp[n]), wple_pkg::flq(mp[n+3]));
      end
      wple_pkg::S_MUL3: begin
        for (int n = 0; n < 3; n++)
          w3[n] <= wple_pkg::sub_sat48(wple_pkg::flq(mp[n]), wple_pkg::flq(mp[n+3]));
      end
      wple_pkg::S_MUL4: begin
        // The negated offsets are the negated floored products minus an inexact
        // correction; only the floored product terms are stored here.
        for (int n = 0; n < 3; n++) begin
          pa[n] <= wple_pkg::flq(mp[n]);
          pb[n] <= wple_pkg::flq(mp[n+3]);
        end
      end
      default: ;
    endcase
  end

  // Negated-offset products: floor(-w*h) = -floor(w*h) - (inexact ? 1 : 0);
  // the inexact flags are registered from the low 16 bits of each product.
  logic neg_a_inexact [3];
  logic neg_b_inexact [3];
  always_ff @(posedge clk) begin
    if (state == wple_pkg::S_MUL4) begin
      for (int n = 0; n < 3; n++) begin
        neg_a_inexact[n] <= (mp[n][15:0] != '0);
        neg_b_inexact[n] <= (mp[n+3][15:0] != '0);
      end
    end
  end

  // Segment generation.
  function automatic logic signed [31:0] pick(input logic s,
                                              input logic signed [31:0] a,
                                              input logic signed [31:0] mn,
                                              input logic signed [31:0] mx);
    return wple_pkg::add_sat(a, s ? mx : mn);
  endfunction

  logic signed [31:0] s_v [3];
  logic signed [31:0] e_v [3];
  logic [2:0] cs, ce;

  always_comb begin
    logic signed [47:0] off;
    logic [1:0] k;
    logic [2:0] kb;
    for (int n = 0; n < 3; n++) begin
      s_v[n] = '0;
      e_v[n] = '0;
    end
    off = '0;
    cs = '0;
    ce = '0;
    k = 2'(idx - 4'd1);
    // Box edge group: three segments per side of the top face.
    kb = (idx >= 4'd9) ? 3'd3 : (idx >= 4'd6) ? 3'd2 : (idx >= 4'd3) ? 3'd1 : 3'd0;
    nseg = 4'd0;
    case (wple_pkg::opcode_t'(cmd.opcode))
      wple_pkg::OP_LINE: begin
        nseg = 4'd0;
        s_v[0] = cmd.ax; s_v[1] = cmd.ay; s_v[2] = cmd.az;
        e_v[0] = cmd.bx; e_v[1] = cmd.by; e_v[2] = cmd.bz;
      end
      wple_pkg::OP_ARROW: begin
        nseg = 4'd4;
        if (idx == 4'd0) begin
          s_v[0] = cmd.ax; s_v[1] = cmd.ay; s_v[2] = cmd.az;
          for (int n = 0; n < 3; n++) e_v[n] = tip[n];
        end else begin
          for (int n = 0; n < 3; n++) begin
            s_v[n] = tip[n];
            case (k)
              2'd0: off = pa[n];
              2'd1: off = -pa[n] - 48'(neg_a_inexact[n]);
              2'd2: off = pb[n];
              default: off = -pb[n] - 48'(neg_b_inexact[n]);
            endcase
            e_v[n] = wple_pkg::add_sat(back[n], wple_pkg::sat48(off));
          end
        end
      end
      default: begin
        nseg = 4'd11;
        case (idx)
          4'd0, 4'd3, 4'd6, 4'd9: begin
            cs = kb; ce = (cs == 3'd3) ? 3'd0 : cs + 3'd1;
          end
          4'd1, 4'd4, 4'd7, 4'd10: begin
            cs = kb; ce = (cs == 3'd3) ? 3'd0 : cs + 3'd1;
            cs = cs + 3'd4; ce = ce + 3'd4;
          end
          default: begin
            cs = kb; ce = cs + 3'd4;
          end
        endcase
        // Corner select: x max for 2,3,6,7; y max for 0,3,4,7; z max for 0..3.
        s_v[0] = pick(cs[1], cmd.ax, cmd.bx, cmd.cx);
        s_v[1] = pick(cs[1:0] == 2'd0 || cs[1:0] == 2'd3, cmd.ay, cmd.by, cmd.cy);
        s_v[2] = pick(!cs[2], cmd.az, cmd.bz, cmd.cz);
        e_v[0] = pick(ce[1], cmd.ax, cmd.bx, cmd.cx);
        e_v[1] = pick(ce[1:0] == 2'd0 || ce[1:0] == 2'd3, cmd.ay, cmd.by, cmd.cy);
        e_v[2] = pick(!ce[2], cmd.az, cmd.bz, cmd.cz);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wple_pkg::S_IDLE;
      idx <= '0;
      seg.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == wple_pkg::S_EMIT && out_free) begin
        seg.valid <= 1'b1;
        idx <= (idx == nseg) ? 4'd0 : idx + 4'd1;
      end else if (seg.ready) begin
        seg.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == wple_pkg::S_EMIT && out_free) begin
      seg.data.start_x <= s_v[0];
      seg.data.start_y <= s_v[1];
      seg.data.start_z <= s_v[2];
      seg.data.end_x <= e_v[0];
      seg.data.end_y <= e_v[1];
      seg.data.end_z <= e_v[2];
      seg.data.line_color <= cmd.rgba;
      seg.data.last_line <= (idx == nseg);
    end
  end
endmodule

### hw/rtl/wireframe_primitive_line_expander.sv
// Top level: debug primitive command to line segment expander.
// A line or box command goes from the queue straight to emission, an arrow
// after 4 multiplier-bank phases; segments then follow one per cycle unless
// seg.ready holds the output back. A command gives 1 line, 5 arrow or 12 box
// segments from the single output register and is dequeued in the idle state.
// Reset (rst, synchronous) empties the command queue and returns the emitter
// to idle; the datapath registers are not reset.
module wireframe_primitive_line_expander #(
  parameter int QueueDepth = wple_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  wple_cmd_if.sink  cmd,
  wple_seg_if.source seg
);
  // The front end accepts commands into a short queue so that a new item
  // can be taken while the back end is still emitting earlier segments.
  logic           q_valid;
  logic           q_pop;
  wple_pkg::cmd_t q_data;

  wple_front #(.Depth(QueueDepth)) u_front (
    .clk(clk), .rst(rst), .cmd(cmd),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  // The back end runs the arrow arithmetic on a shared multiplier bank and
  // walks the segment list of each command.
  wple_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .seg(seg)
  );
endmodule
